// ===== rtl/core/bmps_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit matrix point store package
// Shared widths, command codes and the lowest-set-bit helper.
// ----------------------------------------------------------------------------
package bmps_pkg;

   localparam int DEF_ROWS = 64;
   localparam int DEF_COLS = 32;
   localparam int MAX_COLS = 32;

   localparam int CMD_W   = 3;
   localparam int COORD_W = 8;
   localparam int FROW_W  = 6;
   localparam int FCOL_W  = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ   = 3'd0,
      CMD_SET    = 3'd1,
      CMD_CLEAR  = 3'd2,
      CMD_WRITE  = 3'd3,
      CMD_TOGGLE = 3'd4,
      CMD_FIND   = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POINT,
      ST_SCAN,
      ST_REPORT
   } state_type;

   // Isolates the lowest set bit, then encodes its position.
   function automatic logic [FCOL_W-1:0] lowest_set(input logic [MAX_COLS-1:0] word);
      logic [MAX_COLS-1:0] iso;
      logic [FCOL_W-1:0]   idx;
      iso = word & (~word + MAX_COLS'(1));
      idx = '0;
      for (int i = 0; i < MAX_COLS; i++) begin
         if (iso[i]) begin
            idx = idx | FCOL_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== rtl/core/bmps_req_if.sv =====
// ----------------------------------------------------------------------------
// Bit matrix point store request channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface bmps_req_if;
   import bmps_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [COORD_W-1:0] col_index;
   logic [COORD_W-1:0] row_index;
   logic               write_value;

   modport source (output valid, command, col_index, row_index, write_value, input ready);
   modport sink   (input valid, command, col_index, row_index, write_value, output ready);
endinterface

// ===== rtl/core/bmps_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Bit matrix point store response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface bmps_rsp_if;
   import bmps_pkg::*;

   logic              valid;
   logic              ready;
   logic              bit_value;
   logic              found;
   logic [FROW_W-1:0] found_row;
   logic [FCOL_W-1:0] found_col;

   modport source (output valid, bit_value, found, found_row, found_col, input ready);
   modport sink   (input valid, bit_value, found, found_row, found_col, output ready);
endinterface

// ===== rtl/core/bit_matrix_point_store_first_set.sv =====
// Point commands: the result word is registered in POINT once the output is free.
// Find: SCAN reads one memory row per cycle, then REPORT registers the result.
// One command is worked on at a time; the next word is taken in the cycle
// after the result is registered, even while that result still waits.
// Reset clears the per-row valid flags at once; no clearing sweep.
// ----------------------------------------------------------------------------
// Bit matrix point store with first-set search
// Row-organised bit matrix in a synchronous memory, read-modify-write per point
// command, with a column-major search for the first set point.
// ----------------------------------------------------------------------------
module bit_matrix_point_store_first_set #(
   parameter int ROWS = bmps_pkg::DEF_ROWS,
   parameter int COLS = bmps_pkg::DEF_COLS
) (
   input logic         clock,
   input logic         reset,
   bmps_req_if.sink    req_chan,
   bmps_rsp_if.source  rsp_chan
);
   import bmps_pkg::*;

   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_AW = (COLS > 1) ? $clog2(COLS) : 1;

   state_type state_ff, state_in;

   logic [CMD_W-1:0]  command_ff;
   logic [COL_AW-1:0] col_ff;
   logic [ROW_AW-1:0] row_addr_ff;
   logic              in_range_ff;
   logic              wv_ff;

   logic [COLS-1:0]   mem_array [ROWS];
   logic [ROWS-1:0]   row_valid_ff;
   logic [COLS-1:0]   rd_data_ff;
   logic              rd_valid_ff;
   logic [ROW_AW-1:0] rd_addr;

   logic [ROW_AW-1:0] scan_row_ff;
   logic              scan_last;
   logic              best_found_ff;
   logic [COL_AW-1:0] best_col_ff;
   logic [ROW_AW-1:0] best_row_ff;

   logic              rsp_valid_ff;
   logic              bit_value_ff;
   logic              found_ff;
   logic [FROW_W-1:0] found_row_ff;
   logic [FCOL_W-1:0] found_col_ff;

   logic              accept;
   logic              out_free;
   logic              emit_point;
   logic              emit_find;
   logic              req_row_ok;
   logic              req_col_ok;
   logic [COLS-1:0]   word;
   logic [COLS-1:0]   mask;
   logic [COLS-1:0]   new_word;
   logic              wr_cmd;
   logic              wr_en;
   logic              point_bit;
   logic [COL_AW-1:0] row_low_col;

   assign accept     = req_chan.valid && req_chan.ready;
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_row_ok = {1'b0, req_chan.row_index} < (COORD_W + 1)'(ROWS);
   assign req_col_ok = req_chan.col_index < COORD_W'(COLS);
   assign scan_last  = scan_row_ff == ROW_AW'(ROWS - 1);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_chan.command == CMD_FIND) ? ST_SCAN : ST_POINT;
            end
         end
         ST_POINT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_chan.ready = 1'b0;
      emit_point     = 1'b0;
      emit_find      = 1'b0;
      rd_addr        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            rd_addr        = (req_chan.command == CMD_FIND || !req_row_ok) ? '0
                                : ROW_AW'(req_chan.row_index);
         end
         ST_POINT: begin
            emit_point = out_free;
            rd_addr    = row_addr_ff;
         end
         ST_SCAN: begin
            rd_addr = scan_last ? '0 : ROW_AW'(scan_row_ff + ROW_AW'(1));
         end
         ST_REPORT: begin
            emit_find = out_free;
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         command_ff  <= req_chan.command;
         col_ff      <= COL_AW'(req_chan.col_index);
         row_addr_ff <= req_row_ok ? ROW_AW'(req_chan.row_index) : '0;
         in_range_ff <= req_row_ok && req_col_ok;
         wv_ff       <= req_chan.write_value;
      end
   end

   // Rows never written read as zero.
   assign word = rd_valid_ff ? rd_data_ff : '0;
   assign mask = COLS'(1) << col_ff;

   always_comb begin
      new_word = word;
      wr_cmd   = 1'b1;
      case (command_ff)
         CMD_SET:    new_word = word | mask;
         CMD_CLEAR:  new_word = word & ~mask;
         CMD_WRITE:  new_word = wv_ff ? (word | mask) : (word & ~mask);
         CMD_TOGGLE: new_word = word ^ mask;
         default:    wr_cmd   = 1'b0;
      endcase
   end

   assign wr_en     = emit_point && in_range_ff && wr_cmd;
   assign point_bit = in_range_ff && (command_ff == CMD_READ) && ((word & mask) != '0);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[row_addr_ff] <= new_word;
      end
      rd_data_ff <= mem_array[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[row_addr_ff] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   // Rows arrive in ascending order, so a strictly lower column is needed to
   // replace the current best point.
   assign row_low_col = COL_AW'(lowest_set(MAX_COLS'(word)));

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && accept) begin
         scan_row_ff   <= '0;
         best_found_ff <= 1'b0;
         best_col_ff   <= '0;
         best_row_ff   <= '0;
      end else if (state_ff == ST_SCAN) begin
         scan_row_ff <= ROW_AW'(scan_row_ff + ROW_AW'(1));
         if (word != '0 && (!best_found_ff || row_low_col < best_col_ff)) begin
            best_found_ff <= 1'b1;
            best_col_ff   <= row_low_col;
            best_row_ff   <= scan_row_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_point || emit_find) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_point) begin
         bit_value_ff <= point_bit;
         found_ff     <= 1'b0;
         found_row_ff <= '0;
         found_col_ff <= '0;
      end else if (emit_find) begin
         bit_value_ff <= 1'b0;
         found_ff     <= best_found_ff;
         found_row_ff <= FROW_W'(best_row_ff);
         found_col_ff <= FCOL_W'(best_col_ff);
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.bit_value = bit_value_ff;
   assign rsp_chan.found     = found_ff;
   assign rsp_chan.found_row = found_row_ff;
   assign rsp_chan.found_col = found_col_ff;

endmodule

// ===== rtl/core/bmps_checker.sv =====
// ----------------------------------------------------------------------------
// Bit matrix point store checker
// Port-level properties of the request and response channels.
// ----------------------------------------------------------------------------
module bmps_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [bmps_pkg::CMD_W-1:0] req_command,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_bit_value,
   input logic                       rsp_found,
   input logic [bmps_pkg::FROW_W-1:0] rsp_found_row,
   input logic [bmps_pkg::FCOL_W-1:0] rsp_found_col
);
   import bmps_pkg::*;

   // A stalled result word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bit_value) && $stable(rsp_found)
         && $stable(rsp_found_row) && $stable(rsp_found_col))
      else $error("response word changed while stalled");

   // A word without a found point, a point result or an empty search, reports the origin.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_found_row == '0 && rsp_found_col == '0)
      else $error("coordinates reported without a found point");

   // A point value and a search hit never share one word.
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_bit_value && rsp_found))
      else $error("point value and found flag both set");

   // A point command accepted into a free output has its result word valid once POINT registers it.
   a_point_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command != CMD_FIND && !rsp_valid |=> ##1 rsp_valid)
      else $error("point command result late");

endmodule

bind bit_matrix_point_store_first_set bmps_checker u_bmps_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_command   (req_chan.command),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_bit_value (rsp_chan.bit_value),
   .rsp_found     (rsp_chan.found),
   .rsp_found_row (rsp_chan.found_row),
   .rsp_found_col (rsp_chan.found_col)
);
